// ===== rtl/mrfp_pkg.sv =====
// Shared types, constants and frame-length decode for the motor reply frame parser.
package mrfp_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] len_type;

   // Configuration register indexes
   typedef enum logic [7:0] {
      CSR_EXPECTED_ADDR = 8'd0,
      CSR_TAIL_BYTE     = 8'd1,
      CSR_POSITION_CODE = 8'd2,
      CSR_SPEED_CODE    = 8'd3,
      CSR_SHORT_CODES   = 8'd4
   } csr_index_type;

   localparam byte_type ERROR_CODE    = 8'h00;
   localparam len_type  LEN_POSITION  = 4'd8;
   localparam len_type  LEN_SPEED     = 4'd6;
   localparam len_type  LEN_SHORT     = 4'd4;
   localparam len_type  LEN_NONE      = 4'd0;
   localparam int       SHORT_COUNT   = 6;
   localparam int       CSR_DATA_W    = 48;

   // Per-cycle control handed to every window cell
   typedef struct packed {
      logic shift;   // take the byte of the next cell up
      logic load;    // accept the incoming byte (overrides shift)
   } cell_ctrl_type;

   // Frame length by function code; position beats speed beats the 4-byte codes
   function automatic len_type frame_len(
      input byte_type                  code,
      input byte_type                  position_code,
      input byte_type                  speed_code,
      input logic [CSR_DATA_W-1:0]     short_codes
   );
      logic short_hit;
      short_hit = (code == ERROR_CODE);
      for (int k = 0; k < SHORT_COUNT; k++) begin
         if (short_codes[8*k +: 8] == code) begin
            short_hit = 1'b1;
         end
      end
      if (code == position_code) begin
         return LEN_POSITION;
      end else if (code == speed_code) begin
         return LEN_SPEED;
      end else if (short_hit) begin
         return LEN_SHORT;
      end else begin
         return LEN_NONE;
      end
   endfunction

endpackage

// ===== rtl/mrfp_cell.sv =====
// One byte cell of the receive window; shifts toward the head or loads a new byte.
module mrfp_cell
   import mrfp_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  byte_type      up_byte,
   input  byte_type      new_byte,
   output byte_type      cell_byte
);

   byte_type byte_ff;
   byte_type byte_in;

   // Load wins; otherwise move one place toward the head when shifting
   always_comb begin
      if (ctrl.load) begin
         byte_in = new_byte;
      end else if (ctrl.shift) begin
         byte_in = up_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== rtl/motor_reply_frame_parser.sv =====
// Reply frame parser: byte window as a chain of cells, resync sequencer and reply register.
// Result: a frame's result is registered in the scan state after its tail byte is taken
//   and after any bytes dropped in the search before it, once the reply register is free.
// Input: a byte is taken only in the idle state; the input stalls while the window is scanned
//   and while a good frame is removed; the window shifts one byte a cycle during removal.
// Reset: window empty, reject counter zero, configuration registers at their default values.
module motor_reply_frame_parser
   import mrfp_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   // byte input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   // reply output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_reply_code,
   output logic [7:0]             rsp_reply_status,
   output logic signed [32:0]     rsp_position,
   output logic signed [16:0]     rsp_rpm,
   output logic [31:0]            rsp_reject_total,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REMOVE
   } state_type;

   state_type             state_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic [31:0]           reject_ff;
   len_type               remain_ff;
   byte_type              expected_addr_ff;
   byte_type              tail_byte_ff;
   byte_type              position_code_ff;
   byte_type              speed_code_ff;
   logic [CSR_DATA_W-1:0] short_codes_ff;
   logic                  rsp_valid_ff;
   byte_type              rsp_code_ff;
   byte_type              rsp_status_ff;
   logic signed [32:0]    rsp_position_ff;
   logic signed [16:0]    rsp_rpm_ff;
   logic [31:0]           rsp_reject_ff;

   byte_type      cell_bytes [WINDOW_DEPTH];
   cell_ctrl_type cell_ctrl  [WINDOW_DEPTH];

   logic              accept;
   logic              full;
   logic [IDX_W-1:0]  load_idx;
   len_type           head_len;
   byte_type          tail_seen;
   logic              addr_ok;
   logic              sign_bad;
   logic              frame_bad;
   logic              out_free;
   logic              scan_drop;
   logic              scan_done;
   logic              scan_emit;
   logic              shift_all;
   logic [31:0]       pos_mag;
   logic [15:0]       rpm_mag;
   logic signed [32:0] pos_value;
   logic signed [16:0] rpm_value;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == FULL_FILL);
   assign load_idx  = full ? LAST_IDX : fill_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Head-of-window frame check
   always_comb begin
      head_len = frame_len(cell_bytes[1], position_code_ff, speed_code_ff, short_codes_ff);
      case (head_len)
         LEN_POSITION: tail_seen = cell_bytes[7];
         LEN_SPEED:    tail_seen = cell_bytes[5];
         default:      tail_seen = cell_bytes[3];
      endcase
      addr_ok   = (cell_bytes[0] == expected_addr_ff);
      sign_bad  = ((head_len == LEN_POSITION) || (head_len == LEN_SPEED)) &&
                  (cell_bytes[2] > 8'd1);
      frame_bad = (tail_seen != tail_byte_ff) || sign_bad;
      scan_done = 1'b0;
      scan_drop = 1'b0;
      scan_emit = 1'b0;
      if (fill_ff == '0) begin
         scan_done = 1'b1;
      end else if (!addr_ok) begin
         scan_drop = 1'b1;
      end else if (fill_ff < FILL_W'(2)) begin
         scan_done = 1'b1;
      end else if (head_len == LEN_NONE) begin
         scan_drop = 1'b1;
      end else if (fill_ff < FILL_W'(head_len)) begin
         scan_done = 1'b1;
      end else if (frame_bad) begin
         scan_drop = 1'b1;
      end else begin
         scan_emit = 1'b1;
      end
   end

   // Reply payload values
   always_comb begin
      pos_mag   = {cell_bytes[3], cell_bytes[4], cell_bytes[5], cell_bytes[6]};
      rpm_mag   = {cell_bytes[3], cell_bytes[4]};
      pos_value = (cell_bytes[2] != 8'd0) ? -$signed({1'b0, pos_mag})
                                          : $signed({1'b0, pos_mag});
      rpm_value = (cell_bytes[2] != 8'd0) ? -$signed({1'b0, rpm_mag})
                                          : $signed({1'b0, rpm_mag});
   end

   // Window shift: drop on a full accept, a rejected head byte, or frame removal
   assign shift_all = (accept && full) ||
                      ((state_ff == S_SCAN) && scan_drop) ||
                      (state_ff == S_REMOVE);

   // Chain of window cells
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      byte_type up_byte;
      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign up_byte = 8'h00;
      end else begin : g_mid
         assign up_byte = cell_bytes[i+1];
      end
      assign cell_ctrl[i].shift = shift_all;
      assign cell_ctrl[i].load  = accept && (load_idx == IDX_W'(i));
      mrfp_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .up_byte   (up_byte),
         .new_byte  (req_in_byte),
         .cell_byte (cell_bytes[i])
      );
   end

   // Sequencer, counters, configuration and reply register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         fill_ff          <= '0;
         reject_ff        <= '0;
         remain_ff        <= '0;
         expected_addr_ff <= 8'h01;
         tail_byte_ff     <= 8'h6B;
         position_code_ff <= 8'h36;
         speed_code_ff    <= 8'h35;
         short_codes_ff   <= 48'h3AF3FDF6FE0A;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_EXPECTED_ADDR: expected_addr_ff <= csr_wr_data[7:0];
               CSR_TAIL_BYTE:     tail_byte_ff     <= csr_wr_data[7:0];
               CSR_POSITION_CODE: position_code_ff <= csr_wr_data[7:0];
               CSR_SPEED_CODE:    speed_code_ff    <= csr_wr_data[7:0];
               CSR_SHORT_CODES:   short_codes_ff   <= csr_wr_data;
               default: ;
            endcase
         end
         // Taken reply leaves unless a new one replaces it in the same cycle
         if (rsp_valid_ff && !rsp_stall && !((state_ff == S_SCAN) && scan_emit)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (full) begin
                     reject_ff <= reject_ff + 32'd1;
                  end else begin
                     fill_ff <= fill_ff + FILL_W'(1);
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  state_ff <= S_IDLE;
               end else if (scan_drop) begin
                  fill_ff   <= fill_ff - FILL_W'(1);
                  reject_ff <= reject_ff + 32'd1;
               end else if (scan_emit && out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_code_ff     <= cell_bytes[1];
                  rsp_status_ff   <= cell_bytes[2];
                  rsp_position_ff <= (head_len == LEN_POSITION) ? pos_value : '0;
                  rsp_rpm_ff      <= (head_len == LEN_SPEED) ? rpm_value : '0;
                  rsp_reject_ff   <= reject_ff;
                  remain_ff       <= head_len;
                  state_ff        <= S_REMOVE;
               end
            end
            S_REMOVE: begin
               fill_ff   <= fill_ff - FILL_W'(1);
               remain_ff <= remain_ff - 4'd1;
               if (remain_ff == 4'd1) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_code   = rsp_code_ff;
   assign rsp_reply_status = rsp_status_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_rpm          = rsp_rpm_ff;
   assign rsp_reject_total = rsp_reject_ff;

endmodule
